>>> src/bwc_pkg.sv
// Package for the bit width converter: widths, register indexes, shared types
// and helper functions. No dependencies; used by bwc_step and the top level.

package bwc_pkg;

  localparam int MAX_WIDTH = 64;                     // widest input or output word
  localparam int WORD_W    = 64;                     // port word width
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);  // holds 0..MAX_WIDTH
  localparam int REG_W     = 7;                      // config register width
  localparam int ADDR_W    = 2;                      // config index width

  localparam logic [ADDR_W-1:0] REG_INPUT_WIDTH  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_OUTPUT_WIDTH = ADDR_W'(1);

  localparam logic [REG_W-1:0] WIDTH_RESET = REG_W'(8);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Result of one step of the datapath on the held item.
  typedef struct packed {
    logic  emit;      // an output word is complete this step
    logic  done;      // held item fully consumed after this step
    logic  last;      // emitted word is the final one of the item
    word_t out_word;
    cnt_t  rem_nxt;   // bits of the item still to be packed
    word_t pend_nxt;
    cnt_t  pcnt_nxt;
  } step_res_t;

  // Zero reads as 1, anything above the limit reads as the limit.
  function automatic cnt_t eff_width(logic [REG_W-1:0] w);
    cnt_t r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (w > REG_W'(MAX_WIDTH)) begin
      r = CNT_W'(MAX_WIDTH);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

  // Low w bits set; a shift of the full width or more leaves all ones.
  function automatic word_t low_mask(cnt_t w);
    return ~({WORD_W{1'b1}} << w);
  endfunction

endpackage

>>> src/bwc_step.sv
// One packing step: from the held input bits and the pending buffer, builds
// the next output word (if complete) and the next buffer state. Uses bwc_pkg.

module bwc_step (
  input  bwc_pkg::word_t     word,
  input  bwc_pkg::cnt_t      rem,
  input  bwc_pkg::word_t     pend,
  input  bwc_pkg::cnt_t      pcnt,
  input  bwc_pkg::cnt_t      ow,
  output bwc_pkg::step_res_t res
);

  logic [bwc_pkg::CNT_W:0] total;
  bwc_pkg::cnt_t           take;
  bwc_pkg::cnt_t           shamt;
  bwc_pkg::cnt_t           rem_left;
  bwc_pkg::word_t          word_m;
  bwc_pkg::word_t          part;
  logic                    emit;
  logic                    done;

  assign total    = {1'b0, pcnt} + {1'b0, rem};
  assign emit     = total >= {1'b0, ow};
  // bits still missing from the word being built
  assign take     = ow - pcnt;
  assign shamt    = rem - take;
  assign rem_left = rem - take;
  assign word_m   = word & bwc_pkg::low_mask(rem);
  assign part     = (word_m >> shamt) & bwc_pkg::low_mask(take);
  assign done     = !emit || (rem_left < ow);

  always_comb begin
    res.emit     = emit;
    res.done     = done;
    res.last     = emit && done;
    res.out_word = (pend << take) | part;
    res.rem_nxt  = rem_left;
    if (!emit) begin
      // too few bits: everything goes to the buffer
      res.pend_nxt = (pend << rem) | word_m;
      res.pcnt_nxt = bwc_pkg::CNT_W'(total);
    end else if (done) begin
      res.pend_nxt = word_m & bwc_pkg::low_mask(rem_left);
      res.pcnt_nxt = rem_left;
    end else begin
      res.pend_nxt = '0;
      res.pcnt_nxt = '0;
    end
  end

endmodule

>>> src/bit_width_converter_top.sv
// Bit width converter (gearbox), MSB-first: top level with config registers,
// item register, pending buffer and output register. Uses bwc_pkg, bwc_step.
//
//   port group | dir | handshake              | payload
//   in_        | in  | in_valid / in_ready    | in_word[63:0]
//   out_       | out | out_valid / out_ready  | out_word[63:0], out_last_of_run
//   cfg_       | in  | cfg_valid / cfg_ready  | cfg_addr[1:0], cfg_wdata[6:0]
//
// An accepted word is held in the item register, then emits one output word
// per cycle unless out_ready stalls: in_ready stays low until the item's last
// step, as the input is paced by the single step unit.
// Output is registered; a stall on out_ready stops the step unit only when it
// has a word to emit. Reset (sync, active low) sets both widths to 8 and
// clears the buffer. cfg_ready is always high; a known index clears the buffer.

module bit_width_converter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [63:0]                  in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [63:0]                  out_word,
  output logic                         out_last_of_run,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bwc_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [bwc_pkg::REG_W-1:0]    cfg_wdata
);

  logic [bwc_pkg::REG_W-1:0] iw_reg_r, ow_reg_r;
  bwc_pkg::cnt_t             iw_eff, ow_eff;
  logic                      item_vld_r;
  bwc_pkg::word_t            word_r;
  bwc_pkg::cnt_t             rem_r;
  bwc_pkg::word_t            pend_r;
  bwc_pkg::cnt_t             pcnt_r;
  logic                      out_valid_r;
  bwc_pkg::word_t            out_word_r;
  logic                      out_last_r;

  bwc_pkg::step_res_t        res;
  logic                      out_free;
  logic                      step_go;
  logic                      in_xfer;
  logic                      cfg_xfer;
  logic                      cfg_hit;

  bwc_step u_step (
    .word (word_r),
    .rem  (rem_r),
    .pend (pend_r),
    .pcnt (pcnt_r),
    .ow   (ow_eff),
    .res  (res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign step_go  = item_vld_r && (!res.emit || out_free);
  assign in_ready = !item_vld_r || (step_go && res.done);
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_xfer &&
                    (cfg_addr == bwc_pkg::REG_INPUT_WIDTH ||
                     cfg_addr == bwc_pkg::REG_OUTPUT_WIDTH);

  assign iw_eff = bwc_pkg::eff_width(iw_reg_r);
  assign ow_eff = bwc_pkg::eff_width(ow_reg_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_reg_r <= bwc_pkg::WIDTH_RESET;
      ow_reg_r <= bwc_pkg::WIDTH_RESET;
    end else if (cfg_xfer) begin
      if (cfg_addr == bwc_pkg::REG_INPUT_WIDTH) begin
        iw_reg_r <= cfg_wdata;
      end
      if (cfg_addr == bwc_pkg::REG_OUTPUT_WIDTH) begin
        ow_reg_r <= cfg_wdata;
      end
    end
  end

  // item register and pending buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      pend_r     <= '0;
      pcnt_r     <= '0;
    end else begin
      if (in_xfer) begin
        item_vld_r <= 1'b1;
      end else if (step_go && res.done) begin
        item_vld_r <= 1'b0;
      end
      if (cfg_hit) begin
        pend_r <= '0;
        pcnt_r <= '0;
      end else if (step_go) begin
        pend_r <= res.pend_nxt;
        pcnt_r <= res.pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_r <= in_word & bwc_pkg::low_mask(iw_eff);
      rem_r  <= iw_eff;
    end else if (step_go) begin
      rem_r  <= res.rem_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && res.emit) begin
      out_word_r <= res.out_word;
      out_last_r <= res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_last_of_run = out_last_r;

  // buffer never holds a full output word
  a_pcnt_below_ow: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r < ow_eff)
    else $error("pending count reached output width");

  // a held item always has bits left to pack
  a_item_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r |-> rem_r != '0)
    else $error("held item has no bits left");

  // emitted word carries nothing above the output width
  a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && res.emit |=>
      (out_word_r & ~bwc_pkg::low_mask($past(ow_eff))) == '0)
    else $error("output word has bits above output width");

endmodule
